// File: sv/sgh_pkg.sv
// Package with the shared widths, codes and types of the scaled gray histogram unit.
`default_nettype none

package sgh_pkg;

    localparam int PIX_W    = 8;
    localparam int HEIGHT_W = 16;
    localparam int LOG2_W   = 4;
    localparam int QSTEP_W  = 4;

    typedef logic [PIX_W-1:0]    t_pix;
    typedef logic [HEIGHT_W-1:0] t_height;
    typedef logic [LOG2_W-1:0]   t_log2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_BINS_LOG2  = 1'b0;
    localparam logic REG_MAX_HEIGHT = 1'b1;

    localparam t_log2   BINS_LOG2_RST  = 4'd8;
    localparam t_height MAX_HEIGHT_RST = 16'd10;

endpackage

`default_nettype wire

// File: sv/sgh_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module sgh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/scaled_gray_histogram_unit.sv
// Top level of the scaled gray histogram unit: bin store, peak tracking and scaled read-out.
`default_nettype none

// Pixel add requests are taken one per cycle while no read is being handled:
// each reads its bin count from the synchronous RAM and writes the incremented,
// saturated count back in the next cycle, with the last write forwarded to the
// following request when both hit the same bin. A read request holds back the
// next request until it is done: the count is fetched and multiplied by
// max_height, a restoring divider produces the 16-bit quotient one bit per
// cycle, the output register is loaded, and ready returns back in idle.
// A read of a bad or empty bin, or one made while the peak is zero, skips the
// divider. A result that still waits in the output register holds a finished
// read back until it is taken. Bin counts read as zero after reset through a
// valid bit per bin, so no clearing pass is needed. Configuration writes take
// effect at once and must only be issued while the unit is idle.
module scaled_gray_histogram_unit #(
    parameter int BINS_MAX    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // pixel_value, bin_select
    input  wire logic        i_s_axis_tuser,   // command
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,   // scaled_height
    output logic             o_m_axis_tuser    // bad_bin
);

    localparam int AW     = $clog2(BINS_MAX);
    localparam int LG_MAX = $clog2(BINS_MAX + 1) - 1;
    localparam int PW     = COUNT_WIDTH + sgh_pkg::HEIGHT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [COUNT_WIDTH-1:0] COUNT_SAT;
    assign COUNT_SAT = '1;

    sgh_pkg::t_log2   r_bins_log2;
    sgh_pkg::t_height r_max_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_log2  <= sgh_pkg::BINS_LOG2_RST;
            r_max_height <= sgh_pkg::MAX_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sgh_pkg::REG_BINS_LOG2:  r_bins_log2  <= i_cfg_wdata[sgh_pkg::LOG2_W-1:0];
                sgh_pkg::REG_MAX_HEIGHT: r_max_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    sgh_pkg::t_log2 w_lg;
    sgh_pkg::t_log2 w_shift;
    sgh_pkg::t_pix  w_pix;
    sgh_pkg::t_pix  w_sel;
    logic           w_accept;
    logic           w_sel_bad;
    logic [AW-1:0]  w_addr;

    always_comb begin
        priority if (r_bins_log2 == '0) begin
            w_lg = sgh_pkg::t_log2'(1);
        end else if (r_bins_log2 > sgh_pkg::t_log2'(LG_MAX)) begin
            w_lg = sgh_pkg::t_log2'(LG_MAX);
        end else begin
            w_lg = r_bins_log2;
        end
    end

    assign w_pix     = i_s_axis_tdata[7:0];
    assign w_sel     = i_s_axis_tdata[15:8];
    assign w_shift   = sgh_pkg::t_log2'(sgh_pkg::PIX_W) - w_lg;
    assign w_sel_bad = (w_sel >> w_lg) != '0;
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_addr    = (i_s_axis_tuser == sgh_pkg::CMD_READ) ? AW'(w_sel) : AW'(w_pix >> w_shift);

    logic                   r_s1_v;
    logic                   r_s1_cmd;
    logic                   r_s1_bad;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_wr_v;
    logic [AW-1:0]          r_wr_addr;
    logic [COUNT_WIDTH-1:0] r_wr_data;
    logic [BINS_MAX-1:0]    r_valid;
    logic [COUNT_WIDTH-1:0] r_peak;
    logic [COUNT_WIDTH-1:0] w_rdata;
    logic [COUNT_WIDTH-1:0] w_count;
    logic [COUNT_WIDTH-1:0] w_count_inc;
    logic                   w_add;
    logic                   w_rd;

    sgh_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(BINS_MAX)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (w_add),
        .i_waddr(r_s1_addr),
        .i_wdata(w_count_inc),
        .i_re   (w_accept),
        .i_raddr(w_addr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        priority if (r_wr_v && (r_wr_addr == r_s1_addr)) begin
            w_count = r_wr_data;
        end else if (r_valid[r_s1_addr]) begin
            w_count = w_rdata;
        end else begin
            w_count = '0;
        end
    end

    assign w_count_inc = (w_count == COUNT_SAT) ? w_count : w_count + 1'b1;
    assign w_add       = r_s1_v && (r_s1_cmd == sgh_pkg::CMD_ADD);
    assign w_rd        = r_s1_v && (r_s1_cmd == sgh_pkg::CMD_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_wr_v  <= 1'b0;
            r_valid <= '0;
            r_peak  <= '0;
        end else begin
            r_s1_v <= w_accept;
            r_wr_v <= w_add;
            if (w_add) begin
                r_valid[r_s1_addr] <= 1'b1;
                if (w_count_inc > r_peak) begin
                    r_peak <= w_count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd  <= i_s_axis_tuser;
            r_s1_bad  <= w_sel_bad;
            r_s1_addr <= w_addr;
        end
        if (w_add) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= w_count_inc;
        end
    end

    logic [1:0]                   r_state;
    logic [sgh_pkg::QSTEP_W-1:0]  r_step;
    logic [PW-1:0]                r_rem;
    logic [PW-1:0]                r_dvs;
    sgh_pkg::t_height             r_quo;
    logic                         r_bad;
    logic                         r_out_v;
    sgh_pkg::t_height             r_out_h;
    logic                         r_out_bad;
    logic                         w_ge;
    logic                         w_out_free;
    logic                         w_zero;

    assign w_ge       = r_rem >= r_dvs;
    assign w_out_free = !r_out_v || i_m_axis_tready;
    assign w_zero     = r_s1_bad || (w_count == '0) || (r_peak == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_rd) begin
                        r_state <= w_zero ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_rd) begin
            r_rem  <= PW'(w_count) * PW'(r_max_height);
            r_dvs  <= PW'(r_peak) << (sgh_pkg::HEIGHT_W - 1);
            r_quo  <= '0;
            r_bad  <= r_s1_bad;
            r_step <= sgh_pkg::QSTEP_W'(sgh_pkg::HEIGHT_W - 1);
        end else if (r_state == ST_DIV) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs  <= r_dvs >> 1;
            r_quo  <= {r_quo[sgh_pkg::HEIGHT_W-2:0], w_ge};
            r_step <= r_step - 1'b1;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_h   <= r_quo;
            r_out_bad <= r_bad;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE) && !w_rd;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_h;
    assign o_m_axis_tuser  = r_out_bad;

endmodule

`default_nettype wire

// File: dv/scaled_gray_histogram_unit_tb.sv
// Self-checking testbench for the scaled gray histogram unit, with a local bin-count predictor.
`timescale 1ns / 100ps

module scaled_gray_histogram_unit_tb;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          IDLE_SETTLE  = 30;
    localparam int          PHASE_ITEMS  = 50;
    localparam logic [31:0] COUNT_SAT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             bad_bin;
        sgh_pkg::t_height height;
    } t_height_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic           cmd;
        sgh_pkg::t_pix  pix;
        sgh_pkg::t_pix  sel;
        logic           typed;
        t_height_result res;
        logic           reg_addr;
        logic [15:0]    wdata;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    logic [31:0]      bin_tally [256];
    logic [31:0]      tally_peak;
    sgh_pkg::t_log2   cfg_log2;
    sgh_pkg::t_height cfg_max_height;

    t_height_result expected_heights [$];
    t_stim_row      directed_rows [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 63;

    scaled_gray_histogram_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // pixel_value, bin_select
        .i_s_axis_tuser  (i_s_axis_tuser),   // command
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // scaled_height
        .o_m_axis_tuser  (o_m_axis_tuser)    // bad_bin
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("scaled_gray_histogram_unit_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic int eff_log2();
        if (cfg_log2 == 0) begin
            return 1;
        end
        if (cfg_log2 > 8) begin
            return 8;
        end
        return int'(cfg_log2);
    endfunction

    task automatic predict_request(input logic cmd, input sgh_pkg::t_pix pix,
                                   input sgh_pkg::t_pix sel,
                                   output logic has_res, output t_height_result res);
        int          lg;
        int          bin;
        logic [63:0] count64;
        logic [63:0] height64;
        logic [63:0] peak64;
        lg      = eff_log2();
        has_res = 1'b0;
        res     = '0;
        if (cmd == sgh_pkg::CMD_ADD) begin
            bin = int'(pix >> (8 - lg));
            if (bin_tally[bin] != COUNT_SAT) begin
                bin_tally[bin] = bin_tally[bin] + 1;
            end
            if (bin_tally[bin] > tally_peak) begin
                tally_peak = bin_tally[bin];
            end
        end else begin
            has_res = 1'b1;
            if (int'(sel) >= (1 << lg)) begin
                res.bad_bin = 1'b1;
            end else if (bin_tally[sel] != 0 && tally_peak != 0) begin
                count64  = 64'(bin_tally[sel]);
                peak64   = 64'(tally_peak);
                height64 = 64'(cfg_max_height);
                height64 = (count64 * height64) / peak64;
                res.height = (height64 > 64'hFFFF) ? 16'hFFFF : height64[15:0];
            end
        end
    endtask

    // A request that follows without a gap keeps tvalid high across the edge.
    task automatic send_request(input logic cmd, input sgh_pkg::t_pix pix,
                                input sgh_pkg::t_pix sel,
                                input logic typed, input t_height_result typed_res);
        logic           has_res;
        t_height_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {sel, pix};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_request(cmd, pix, sel, has_res, res);
        if (has_res) begin
            expected_heights.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_heights.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (addr == sgh_pkg::REG_BINS_LOG2) begin
            cfg_log2 = data[sgh_pkg::LOG2_W-1:0];
        end else begin
            cfg_max_height = data;
        end
    endtask

    task automatic item_row(input logic cmd, input sgh_pkg::t_pix pix,
                            input sgh_pkg::t_pix sel);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.cmd  = cmd;
        row.pix  = pix;
        row.sel  = sel;
        directed_rows.push_back(row);
    endtask

    task automatic typed_read_row(input sgh_pkg::t_pix sel, input sgh_pkg::t_height height,
                                  input logic bad);
        t_stim_row row;
        row             = '0;
        row.kind        = ROW_ITEM;
        row.cmd         = sgh_pkg::CMD_READ;
        row.pix         = 8'($urandom);
        row.sel         = sel;
        row.typed       = 1'b1;
        row.res.height  = height;
        row.res.bad_bin = bad;
        directed_rows.push_back(row);
    endtask

    task automatic cfg_row(input logic addr, input logic [15:0] data);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.reg_addr = addr;
        row.wdata    = data;
        directed_rows.push_back(row);
    endtask

    task automatic run_phase(input int n_items);
        int            bin_count;
        int            pick;
        logic [15:0]   value;
        sgh_pkg::t_pix hot;
        sgh_pkg::t_pix pix;
        sgh_pkg::t_pix sel;
        logic          cmd;
        wait_idle();
        pick = $urandom_range(11);
        if (pick == 0) begin
            value = '0;
        end else if (pick == 1) begin
            value = 16'($urandom_range(15, 9));
        end else if (pick < 4) begin
            value = 16'd8;
        end else if (pick == 4) begin
            value = 16'd1;
        end else begin
            value = 16'($urandom_range(8, 1));
        end
        write_reg(sgh_pkg::REG_BINS_LOG2, value);
        pick = $urandom_range(9);
        if (pick == 0) begin
            value = '0;
        end else if (pick == 1) begin
            value = 16'hFFFF;
        end else if (pick == 2) begin
            value = 16'($urandom_range(15, 1));
        end else begin
            value = 16'($urandom_range(65535));
        end
        write_reg(sgh_pkg::REG_MAX_HEIGHT, value);
        bin_count = 1 << eff_log2();
        hot       = 8'($urandom);
        repeat (n_items) begin
            if ($urandom_range(99) < 30) begin
                cmd = sgh_pkg::CMD_READ;
                pix = 8'($urandom);
                if ($urandom_range(99) < 80) begin
                    sel = 8'($urandom_range(bin_count - 1));
                end else begin
                    sel = 8'($urandom);
                end
            end else begin
                cmd = sgh_pkg::CMD_ADD;
                sel = 8'($urandom);
                if ($urandom_range(1) == 1) begin
                    pix = hot ^ 8'($urandom_range(7));
                end else begin
                    pix = 8'($urandom);
                end
            end
            send_request(cmd, pix, sel, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_height_result want;
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_heights.size() == 0) begin
                report_mismatch("result with none expected, height", int'(o_m_axis_tdata), 0);
            end else begin
                want = expected_heights.pop_front();
                if (o_m_axis_tdata !== want.height) begin
                    report_mismatch("scaled_height", int'(o_m_axis_tdata), int'(want.height));
                end
                if (o_m_axis_tuser !== want.bad_bin) begin
                    report_mismatch("bad_bin", int'(o_m_axis_tuser), int'(want.bad_bin));
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = sgh_pkg::REG_BINS_LOG2;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = sgh_pkg::CMD_ADD;
        for (int i = 0; i < 256; i++) begin
            bin_tally[i] = '0;
        end
        tally_peak     = '0;
        cfg_log2       = sgh_pkg::BINS_LOG2_RST;
        cfg_max_height = sgh_pkg::MAX_HEIGHT_RST;

        // Reads with a zero peak, then a full-range store at the reset setting.
        typed_read_row(8'd0, 16'd0, 1'b0);
        typed_read_row(8'd255, 16'd0, 1'b0);
        item_row(sgh_pkg::CMD_ADD, 8'd0, 8'hFF);
        item_row(sgh_pkg::CMD_ADD, 8'd255, 8'h00);
        item_row(sgh_pkg::CMD_ADD, 8'd255, 8'hAA);
        item_row(sgh_pkg::CMD_READ, 8'h5A, 8'd255);
        item_row(sgh_pkg::CMD_READ, 8'hFF, 8'd0);
        typed_read_row(8'd128, 16'd0, 1'b0);
        // Two bins and the largest height; old counts stay in place.
        cfg_row(sgh_pkg::REG_BINS_LOG2, 16'd1);
        cfg_row(sgh_pkg::REG_MAX_HEIGHT, 16'hFFFF);
        typed_read_row(8'd2, 16'd0, 1'b1);
        typed_read_row(8'd255, 16'd0, 1'b1);
        item_row(sgh_pkg::CMD_ADD, 8'h80, 8'h00);
        item_row(sgh_pkg::CMD_ADD, 8'h7F, 8'h00);
        item_row(sgh_pkg::CMD_READ, 8'h00, 8'd1);
        item_row(sgh_pkg::CMD_READ, 8'h00, 8'd0);
        // A bin count log2 of zero behaves as one.
        cfg_row(sgh_pkg::REG_BINS_LOG2, 16'd0);
        item_row(sgh_pkg::CMD_READ, 8'h00, 8'd1);
        typed_read_row(8'd2, 16'd0, 1'b1);
        // Values above eight behave as eight; a zero height scales everything to zero.
        cfg_row(sgh_pkg::REG_BINS_LOG2, 16'd15);
        cfg_row(sgh_pkg::REG_MAX_HEIGHT, 16'd0);
        item_row(sgh_pkg::CMD_ADD, 8'hAA, 8'h55);
        item_row(sgh_pkg::CMD_READ, 8'h00, 8'hAA);
        typed_read_row(8'd255, 16'd0, 1'b0);
        cfg_row(sgh_pkg::REG_BINS_LOG2, 16'd4);
        cfg_row(sgh_pkg::REG_MAX_HEIGHT, 16'd10);
        item_row(sgh_pkg::CMD_ADD, 8'h55, 8'hFF);
        item_row(sgh_pkg::CMD_READ, 8'h00, 8'd5);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].reg_addr, directed_rows[i].wdata);
            end else begin
                send_request(directed_rows[i].cmd, directed_rows[i].pix, directed_rows[i].sel,
                             directed_rows[i].typed, directed_rows[i].res);
            end
        end

        repeat (3) run_phase(PHASE_ITEMS);
        send_idle_pct = 63;
        recv_idle_pct = 13;
        repeat (3) run_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) run_phase(PHASE_ITEMS);

        wait_idle();
        if (error_count == 0) begin
            $display("scaled_gray_histogram_unit_tb: clean");
        end else begin
            $display("scaled_gray_histogram_unit_tb: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/sgh_pkg.sv
sv/sgh_ram.sv
sv/scaled_gray_histogram_unit.sv
dv/scaled_gray_histogram_unit_tb.sv
